// ===== sv/lcs_pkg.sv =====
// ============================================================================
// lcs_pkg
// Shared types and constants of the LCS length engine.
// ============================================================================
package lcs_pkg;

    localparam int SYM_W = 8;
    localparam int LEN_W = 7;
    localparam logic [LEN_W-1:0] LEN_LIMIT = 7'd127;
    localparam logic FUNC_FIRST  = 1'b0;
    localparam logic FUNC_SECOND = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic accept;    // input item taken
        logic row_clear; // row counter to zero
        logic row_init;  // open a row, read column zero
        logic cell_en;   // compute one cell
        logic row_next;  // advance row counter
        logic finish;    // load result, clear counts
    } lcs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty;    // a string is empty
        logic last_col; // cell in work is the last of its row
        logic last_row; // row in work is the last
        logic res_busy; // result register still full
    } lcs_sts_t;

endpackage

// ===== sv/lcs_ram.sv =====
// ============================================================================
// lcs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ============================================================================
module lcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/lcs_dp.sv =====
// ============================================================================
// lcs_dp
// Datapath: string stores, DP row memory, cell update and result register.
// ============================================================================
module lcs_dp
    import lcs_pkg::*;
#(
    parameter int MAX_LEN = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  lcs_cmd_t         cmd,
    output lcs_sts_t         sts,
    input  logic [SYM_W-1:0] s_tdata,
    input  logic             s_tuser,
    input  logic             m_tready,
    output logic             m_tvalid,
    output logic [7:0]       m_tdata,
    output logic             m_tuser
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int SW = (CW > LEN_W) ? CW : LEN_W;

    logic [CW-1:0]    first_count_reg, second_count_reg;
    logic             ovf_reg;
    logic [AW-1:0]    i_reg, j_reg, col_reg;
    logic [CW-1:0]    left_reg, diag_reg;
    logic [LEN_W-1:0] res_len_reg;
    logic             res_ovf_reg, res_valid_reg;

    logic [SYM_W-1:0] first_rdata, second_rdata;
    logic [CW-1:0]    dp_rdata;
    logic             first_we, second_we, first_full, second_full;
    logic [AW-1:0]    col_raddr;
    logic [CW-1:0]    up, best, cand, cur_val;
    logic [SW-1:0]    len_ext;
    logic [LEN_W-1:0] len_sat;

    assign first_full  = (first_count_reg >= CW'(MAX_LEN));
    assign second_full = (second_count_reg >= CW'(MAX_LEN));
    assign first_we    = cmd.accept && (s_tuser == FUNC_FIRST) && !first_full;
    assign second_we   = cmd.accept && (s_tuser == FUNC_SECOND) && !second_full;
    assign col_raddr   = cmd.row_init ? '0 : j_reg;

    lcs_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_first (
        .aclk  (aclk),
        .we    (first_we),
        .waddr (first_count_reg[AW-1:0]),
        .wdata (s_tdata),
        .raddr (i_reg),
        .rdata (first_rdata)
    );

    lcs_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_second (
        .aclk  (aclk),
        .we    (second_we),
        .waddr (second_count_reg[AW-1:0]),
        .wdata (s_tdata),
        .raddr (col_raddr),
        .rdata (second_rdata)
    );

    lcs_ram #(.WIDTH(CW), .DEPTH(MAX_LEN)) u_row (
        .aclk  (aclk),
        .we    (cmd.cell_en),
        .waddr (col_reg),
        .wdata (cur_val),
        .raddr (col_raddr),
        .rdata (dp_rdata)
    );

    // first row sees an all-zero row above it
    always_comb begin
        up      = (i_reg == '0) ? '0 : dp_rdata;
        best    = (up > left_reg) ? up : left_reg;
        cand    = diag_reg + ((first_rdata == second_rdata) ? CW'(1) : CW'(0));
        cur_val = (cand > best) ? cand : best;
    end

    always_comb begin
        len_ext = SW'(left_reg);
        if (sts.empty) begin
            len_sat = '0;
        end else if (len_ext > SW'(LEN_LIMIT)) begin
            len_sat = LEN_LIMIT;
        end else begin
            len_sat = len_ext[LEN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_count_reg  <= '0;
            second_count_reg <= '0;
            ovf_reg          <= 1'b0;
            res_valid_reg    <= 1'b0;
        end else begin
            if (first_we) begin
                first_count_reg <= first_count_reg + CW'(1);
            end
            if (second_we) begin
                second_count_reg <= second_count_reg + CW'(1);
            end
            if (cmd.accept && ((s_tuser == FUNC_FIRST) ? first_full : second_full)) begin
                ovf_reg <= 1'b1;
            end
            if (m_tready && res_valid_reg) begin
                res_valid_reg <= 1'b0;
            end
            if (cmd.finish) begin
                res_valid_reg    <= 1'b1;
                first_count_reg  <= '0;
                second_count_reg <= '0;
                ovf_reg          <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.row_clear) begin
            i_reg <= '0;
        end else if (cmd.row_next) begin
            i_reg <= i_reg + AW'(1);
        end
        if (cmd.row_init) begin
            j_reg    <= AW'(1);
            col_reg  <= '0;
            left_reg <= '0;
            diag_reg <= '0;
        end else if (cmd.cell_en) begin
            j_reg    <= j_reg + AW'(1);
            col_reg  <= col_reg + AW'(1);
            left_reg <= cur_val;
            diag_reg <= up;
        end
        if (cmd.finish) begin
            res_len_reg <= len_sat;
            res_ovf_reg <= ovf_reg;
        end
    end

    assign sts.empty    = (first_count_reg == '0) || (second_count_reg == '0);
    assign sts.last_col = ((CW'(col_reg) + CW'(1)) == second_count_reg);
    assign sts.last_row = ((CW'(i_reg) + CW'(1)) == first_count_reg);
    assign sts.res_busy = res_valid_reg;

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {1'b0, res_len_reg};
    assign m_tuser  = res_ovf_reg;

endmodule

// ===== sv/lcs_ctrl.sv =====
// ============================================================================
// lcs_ctrl
// Controller: string loading, row and cell sequencing, result hand-off.
// ============================================================================
module lcs_ctrl
    import lcs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    input  logic     s_tlast,
    output logic     s_tready,
    output lcs_cmd_t cmd,
    input  lcs_sts_t sts
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_START,
        ST_ROW_START,
        ST_ROW,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg;

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.accept    = s_tvalid && s_tready_reg;
        case (state_reg)
            ST_LOAD: begin
                if (cmd.accept && s_tlast) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                cmd.row_clear = 1'b1;
                state_next    = sts.empty ? ST_FINISH : ST_ROW_START;
            end
            ST_ROW_START: begin
                cmd.row_init = 1'b1;
                state_next   = ST_ROW;
            end
            ST_ROW: begin
                cmd.cell_en = 1'b1;
                if (sts.last_col) begin
                    if (sts.last_row) begin
                        state_next = ST_FINISH;
                    end else begin
                        cmd.row_next = 1'b1;
                        state_next   = ST_ROW_START;
                    end
                end
            end
            ST_FINISH: begin
                if (!sts.res_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            s_tready_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= (state_next == ST_LOAD);
        end
    end

    assign s_tready = s_tready_reg;

    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !sts.res_busy)
        else $error("result overwritten while still held");

    a_ready_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready_reg |-> (state_reg == ST_LOAD) && !cmd.cell_en)
        else $error("input ready outside load");

    a_row_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROW) && sts.last_col && !sts.last_row |=>
            (state_reg == ST_ROW_START))
        else $error("row end did not open next row");

endmodule

// ===== sv/lcs_length.sv =====
// ============================================================================
// lcs_length
// Longest common subsequence length of two byte strings.
// ============================================================================
//  channel | dir | tdata        | tuser          | tlast
//  s_      | in  | symbol [7:0] | func           | last symbol of pair
//  m_      | out | lcs_len[6:0] | overflow       | -
//
//  Loading takes one item per cycle. After the last item the table fill
//  runs one cell per cycle within a row through the DP row RAM, with a
//  row-opening step before each row; skipped if either string is empty.
//  Input is not ready during the fill; the result register holds one
//  result, so loading of the next pair overlaps a stalled output.
//  Synchronous active-low reset; the string stores need no clearing.
module lcs_length
    import lcs_pkg::*;
#(
    parameter int MAX_LEN = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,  // [7:0] symbol
    input  logic       s_tuser,  // [0] func
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,  // [6:0] lcs_len, [7] zero
    output logic       m_tuser   // [0] overflow
);

    lcs_cmd_t cmd;
    lcs_sts_t sts;

    lcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    lcs_dp #(.MAX_LEN(MAX_LEN)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== verif/tb.sv =====
// ============================================================================
// tb
// Self-checking bench for lcs_length: string pairs go in as stream items and
// each LCS length plus overflow flag is checked against an in-bench DP model.
// ============================================================================
module tb;
    import lcs_pkg::*;

    localparam int MAX_SYMS   = 64;
    localparam int FILL_MAX   = MAX_SYMS * (MAX_SYMS + 1) + 2;
    localparam int STALL_STOP = 20000;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             ovf;
    } lcs_result_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00; // [7:0] symbol
    logic       s_tuser  = 1'b0;  // [0] func
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;          // [6:0] lcs_len, [7] zero
    logic       m_tuser;          // [0] overflow

    logic [SYM_W-1:0] first_str  [MAX_SYMS];
    logic [SYM_W-1:0] second_str [MAX_SYMS];
    int               first_len;
    int               second_len;
    logic             ovf_seen;
    lcs_result_t      lcs_expected [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_start     = 0;
    int hold_left      = 0;
    int items_sent     = 0;
    int fail_count     = 0;
    int quiet_cycles   = 0;

    lcs_length u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // row-by-row LCS table over the stored strings
    function automatic logic [LEN_W-1:0] lcs_of_strings();
        logic [LEN_W-1:0] row [MAX_SYMS + 1];
        logic [LEN_W-1:0] diag;
        logic [LEN_W-1:0] up;
        logic [LEN_W-1:0] best;
        logic [LEN_W-1:0] cand;
        for (int j = 0; j <= MAX_SYMS; j++) begin
            row[j] = '0;
        end
        for (int i = 0; i < first_len; i++) begin
            diag = '0;
            for (int j = 1; j <= second_len; j++) begin
                up   = row[j];
                best = (up > row[j-1]) ? up : row[j-1];
                cand = diag + ((first_str[i] == second_str[j-1]) ? 7'd1 : 7'd0);
                if (cand > best) begin
                    best = cand;
                end
                diag   = up;
                row[j] = best;
            end
        end
        return row[second_len];
    endfunction

    task automatic take_symbol(input logic func, input logic [7:0] sym, input logic lst);
        lcs_result_t res;
        if (func == FUNC_FIRST) begin
            if (first_len < MAX_SYMS) begin
                first_str[first_len] = sym;
                first_len++;
            end else begin
                ovf_seen = 1'b1;
            end
        end else begin
            if (second_len < MAX_SYMS) begin
                second_str[second_len] = sym;
                second_len++;
            end else begin
                ovf_seen = 1'b1;
            end
        end
        if (lst) begin
            res.len = lcs_of_strings();
            res.ovf = ovf_seen;
            lcs_expected = {lcs_expected, res};
            first_len  = 0;
            second_len = 0;
            ovf_seen   = 1'b0;
        end
    endtask

    task automatic note_mismatch(input string what);
        fail_count++;
        if (fail_count <= REPORT_MAX) begin
            $display("%0t: mismatch: %s", $time, what);
        end
    endtask

    // called and left at a falling edge
    task automatic send_item(input logic func, input logic [7:0] sym, input logic lst);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        s_tuser  <= func;
        s_tlast  <= lst;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        take_symbol(func, sym, lst);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_pair(input int len_a, input int len_b, input bit mixed);
        logic [7:0] base;
        logic       func;
        int         spread;
        int         n1;
        int         n2;
        int         total;
        base = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0: spread = 1;
            1: spread = 3;
            2: spread = 15;
            default: spread = 255;
        endcase
        n1 = len_a;
        n2 = len_b;
        if (n1 + n2 == 0) begin
            n1 = 1;
        end
        total = n1 + n2;
        for (int k = 0; k < total; k++) begin
            if (n2 == 0) begin
                func = FUNC_FIRST;
            end else if (n1 == 0) begin
                func = FUNC_SECOND;
            end else if (mixed) begin
                func = $urandom_range(0, 1) ? FUNC_SECOND : FUNC_FIRST;
            end else begin
                func = FUNC_FIRST;
            end
            if (func == FUNC_FIRST) begin
                n1--;
            end else begin
                n2--;
            end
            send_item(func, base ^ 8'($urandom_range(0, spread)), k == total - 1);
        end
    endtask

    function automatic int draw_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            return $urandom_range(MAX_SYMS + 1, MAX_SYMS + 8);
        end else if (r < 10) begin
            return $urandom_range(11, MAX_SYMS);
        end
        return $urandom_range(0, 10);
    endfunction

    task automatic test_directed();
        // extremes of the symbol byte
        send_item(FUNC_FIRST,  8'h00, 1'b0);
        send_item(FUNC_FIRST,  8'hFF, 1'b0);
        send_item(FUNC_SECOND, 8'hFF, 1'b0);
        send_item(FUNC_SECOND, 8'h00, 1'b0);
        send_item(FUNC_SECOND, 8'hFF, 1'b1);
        // last on first string, second string empty
        send_item(FUNC_FIRST,  8'h41, 1'b1);
        // first string empty
        send_item(FUNC_SECOND, 8'h41, 1'b0);
        send_item(FUNC_SECOND, 8'h42, 1'b1);
        // mixed order
        send_item(FUNC_SECOND, 8'h10, 1'b0);
        send_item(FUNC_FIRST,  8'h10, 1'b0);
        send_item(FUNC_FIRST,  8'h20, 1'b0);
        send_item(FUNC_SECOND, 8'h20, 1'b1);
        send_item(FUNC_FIRST,  8'hAA, 1'b0);
        send_item(FUNC_SECOND, 8'hAA, 1'b1);
    endtask

    task automatic test_overflow();
        send_pair(MAX_SYMS + 2, 3, 1'b0);
        send_pair(2, MAX_SYMS + 6, 1'b0);
        send_pair(MAX_SYMS, MAX_SYMS, 1'b0);
        send_pair(MAX_SYMS + 1, MAX_SYMS + 1, 1'b1);
    endtask

    // receiver held off while pairs keep coming, so the input stalls
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        hold_start = 1000;
        @(negedge aclk);
        for (int p = 0; p < 5; p++) begin
            send_pair($urandom_range(1, 6), $urandom_range(1, 6), 1'b0);
        end
    endtask

    task automatic test_random(input int send_pct, input int recv_pct, input int n);
        int target;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        target         = items_sent + n;
        while (items_sent < target) begin
            send_pair(draw_len(), draw_len(), $urandom_range(0, 9) == 0);
        end
    endtask

    always @(negedge aclk) begin
        if (hold_start != 0) begin
            hold_left  = hold_start;
            hold_start = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        lcs_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (lcs_expected.size() == 0) begin
                note_mismatch($sformatf("unexpected result tdata=%h tuser=%b",
                                        m_tdata, m_tuser));
            end else begin
                want = lcs_expected.pop_front();
                if (m_tdata !== {1'b0, want.len}) begin
                    note_mismatch($sformatf("lcs_len expected %0d got tdata=%h",
                                            want.len, m_tdata));
                end
                if (m_tuser !== want.ovf) begin
                    note_mismatch($sformatf("overflow expected %b got %b",
                                            want.ovf, m_tuser));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_STOP) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        first_len  = 0;
        second_len = 0;
        ovf_seen   = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_overflow();
        test_backpressure();
        test_random(0, 0, 300);
        test_random(88, 0, 300);
        test_random(0, 88, 300);
        test_random(22, 22, 300);

        s_tvalid <= 1'b0;
        while (lcs_expected.size() != 0) begin
            @(posedge aclk);
        end
        repeat (FILL_MAX) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
